FILE: hdl/tch_pkg.sv
// package: types, codes and helpers shared by the client hello field extractor
`timescale 1ns / 1ps
package tch_pkg;

	// walk position through the record and handshake header
	typedef enum logic [4:0] {
		PH_SEARCH  = 5'd0,
		PH_HSLEN   = 5'd1,
		PH_VER     = 5'd2,
		PH_RANDOM  = 5'd3,
		PH_SIDLEN  = 5'd4,
		PH_SID     = 5'd5,
		PH_CSLEN   = 5'd6,
		PH_CIPHER  = 5'd7,
		PH_CMLEN   = 5'd8,
		PH_CM      = 5'd9,
		PH_EXTSLEN = 5'd10,
		PH_ETYPE   = 5'd11,
		PH_ELEN    = 5'd12,
		PH_ESKIP   = 5'd13,
		PH_PFLEN   = 5'd14,
		PH_PF      = 5'd15,
		PH_CVLEN   = 5'd16,
		PH_CV      = 5'd17,
		PH_DONE    = 5'd18
	} phase_t;

	// kind codes of a result
	typedef enum logic [2:0] {
		KIND_VERSION = 3'd0,
		KIND_CIPHER  = 3'd1,
		KIND_EXT     = 3'd2,
		KIND_CURVE   = 3'd3,
		KIND_POINT   = 3'd4,
		KIND_STATUS  = 3'd5
	} kind_t;

	// header match bytes and extension types of interest
	localparam logic [7:0]  REC_HANDSHAKE  = 8'h16;
	localparam logic [7:0]  HS_CLIENTHELLO = 8'h01;
	localparam logic [15:0] EXT_POINTS     = 16'h000B;
	localparam logic [15:0] EXT_CURVES     = 16'h000A;
	localparam logic [15:0] EXT_PADDING    = 16'h0015;
	localparam logic [15:0] GREASE_MASK    = 16'h0f0f;
	localparam logic [15:0] GREASE_PAT     = 16'h0a0a;

	// fixed skip lengths of the header and the search window depth
	localparam logic [15:0] HSLEN_BYTES  = 16'd3;
	localparam logic [15:0] RANDOM_BYTES = 16'd32;
	localparam logic [2:0]  WIN_DEPTH    = 3'd5;

	// result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic        grease;
		logic        err;
		logic        found;
		logic        last;
	} result_t;

	// up to two results produced by one byte
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} parse_out_t;

	// queue status seen by the top level
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room2;
	} q_stat_t;

	function automatic logic is_grease(input logic [15:0] v);
		is_grease = ((v & GREASE_MASK) == GREASE_PAT) && (v[15:8] == v[7:0]);
	endfunction

endpackage

FILE: hdl/tch_if.sv
// channel interfaces: byte request in, field request out
`timescale 1ns / 1ps
interface tch_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface tch_field_if;
	logic        valid;
	logic        ready;
	logic [2:0]  field_kind;
	logic [15:0] field_value;
	logic        grease_flag;
	logic        end_error;
	logic        hello_found;
	logic        run_last;

	modport source (output valid, output field_kind, output field_value, output grease_flag,
		output end_error, output hello_found, output run_last, input ready);
	modport sink (input valid, input field_kind, input field_value, input grease_flag,
		input end_error, input hello_found, input run_last, output ready);
endinterface

FILE: hdl/tch_parser.sv
// parser: header search and field walk, one byte per accepted request
`timescale 1ns / 1ps
module tch_parser
	import tch_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output parse_out_t po
);

	logic [7:0]  win_q [0:4];
	logic [2:0]  fill_q;
	phase_t      phase_q;
	logic [15:0] skip_q;
	logic [15:0] items_q;
	logic [15:0] ext_rem_q;
	logic [15:0] ext_type_q;
	logic [7:0]  partial_q;
	logic        bif_q;

	logic [7:0]  win_n [0:4];
	logic [2:0]  fill_n;
	phase_t      phase_n;
	logic [15:0] skip_n;
	logic [15:0] items_n;
	logic [15:0] ext_rem_n;
	logic [15:0] ext_type_n;
	logic [7:0]  partial_n;
	logic        bif_n;

	// next state and results for the byte at the input
	always_comb begin
		logic        matched;
		logic        take;
		logic        in_ext;
		logic        left;
		logic        emit;
		kind_t       ekind;
		logic [15:0] eval;
		logic [15:0] v16;
		logic [15:0] skip_dec;
		logic [15:0] items_dec;
		logic [15:0] ext_dec;
		result_t     vres;
		result_t     sres;

		for (int i = 0; i < 5; i++) win_n[i] = win_q[i];
		fill_n     = fill_q;
		phase_n    = phase_q;
		skip_n     = skip_q;
		items_n    = items_q;
		ext_rem_n  = ext_rem_q;
		ext_type_n = ext_type_q;
		partial_n  = partial_q;
		bif_n      = bif_q;
		matched    = 1'b0;
		take       = 1'b0;
		in_ext     = 1'b0;
		emit       = 1'b0;
		ekind      = KIND_VERSION;
		eval       = '0;
		v16        = {partial_q, data_byte};
		skip_dec   = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;
		items_dec  = (items_q != 16'd0) ? items_q - 16'd1 : items_q;
		ext_dec    = (ext_rem_q != 16'd0) ? ext_rem_q - 16'd1 : ext_rem_q;
		left       = (ext_dec != 16'd0);

		unique case (phase_q)
			PH_SEARCH: begin
				matched = (fill_q >= WIN_DEPTH) && (win_q[0] == REC_HANDSHAKE)
					&& (data_byte == HS_CLIENTHELLO);
				for (int i = 0; i < 4; i++) win_n[i] = win_q[i+1];
				win_n[4] = data_byte;
				if (fill_q < WIN_DEPTH) fill_n = fill_q + 3'd1;
				if (matched) begin
					phase_n = PH_HSLEN;
					skip_n  = HSLEN_BYTES;
				end
			end
			PH_HSLEN, PH_RANDOM, PH_SID, PH_CM: begin
				skip_n = skip_dec;
				if (skip_dec == 16'd0) begin
					unique case (phase_q)
						PH_HSLEN:  phase_n = PH_VER;
						PH_RANDOM: phase_n = PH_SIDLEN;
						PH_SID:    phase_n = PH_CSLEN;
						default:   phase_n = PH_EXTSLEN;
					endcase
				end
			end
			PH_VER: begin
				take = 1'b1;
				if (bif_q) begin
					emit    = 1'b1;
					ekind   = KIND_VERSION;
					eval    = v16;
					phase_n = PH_RANDOM;
					skip_n  = RANDOM_BYTES;
				end
			end
			PH_SIDLEN: begin
				skip_n  = {8'd0, data_byte};
				phase_n = (data_byte != 8'd0) ? PH_SID : PH_CSLEN;
			end
			PH_CMLEN: begin
				skip_n  = {8'd0, data_byte};
				phase_n = (data_byte != 8'd0) ? PH_CM : PH_EXTSLEN;
			end
			PH_CSLEN: begin
				take = 1'b1;
				if (bif_q) begin
					items_n = {1'b0, v16[15:1]};
					phase_n = (v16[15:1] != 15'd0) ? PH_CIPHER : PH_CMLEN;
				end
			end
			PH_CIPHER: begin
				take = 1'b1;
				if (bif_q) begin
					emit    = 1'b1;
					ekind   = KIND_CIPHER;
					eval    = v16;
					items_n = items_dec;
					if (items_dec == 16'd0) phase_n = PH_CMLEN;
				end
			end
			PH_EXTSLEN: begin
				take = 1'b1;
				if (bif_q) begin
					ext_rem_n = v16;
					phase_n   = (v16 != 16'd0) ? PH_ETYPE : PH_DONE;
				end
			end
			PH_ETYPE, PH_ELEN, PH_ESKIP, PH_PFLEN, PH_PF, PH_CVLEN, PH_CV: begin
				in_ext    = 1'b1;
				ext_rem_n = ext_dec;
				unique case (phase_q)
					PH_ETYPE: begin
						take = 1'b1;
						if (bif_q) begin
							ext_type_n = v16;
							phase_n    = PH_ELEN;
						end
					end
					PH_ELEN: begin
						take = 1'b1;
						if (bif_q && left) begin
							emit  = 1'b1;
							ekind = KIND_EXT;
							eval  = ext_type_q;
							priority if (ext_type_q == EXT_POINTS) begin
								phase_n = PH_PFLEN;
							end else if (ext_type_q == EXT_CURVES) begin
								phase_n = PH_CVLEN;
							end else if (ext_type_q == EXT_PADDING) begin
								phase_n = PH_DONE;
							end else begin
								skip_n  = v16;
								phase_n = (v16 != 16'd0) ? PH_ESKIP : PH_ETYPE;
							end
						end
					end
					PH_ESKIP: begin
						skip_n = skip_dec;
						if (skip_dec == 16'd0) phase_n = PH_ETYPE;
					end
					PH_PFLEN: begin
						items_n = {8'd0, data_byte};
						phase_n = (data_byte != 8'd0) ? PH_PF : PH_ETYPE;
					end
					PH_PF: begin
						if (left) begin
							emit  = 1'b1;
							ekind = KIND_POINT;
							eval  = {8'd0, data_byte};
						end
						items_n = items_dec;
						if (items_dec == 16'd0) phase_n = PH_ETYPE;
					end
					PH_CVLEN: begin
						take = 1'b1;
						if (bif_q) begin
							items_n = {1'b0, v16[15:1]};
							phase_n = (v16[15:1] != 15'd0) ? PH_CV : PH_ETYPE;
						end
					end
					default: begin
						take = 1'b1;
						if (bif_q) begin
							if (left) begin
								emit  = 1'b1;
								ekind = KIND_CURVE;
								eval  = v16;
							end
							items_n = items_dec;
							if (items_dec == 16'd0) phase_n = PH_ETYPE;
						end
					end
				endcase
			end
			default: phase_n = PH_DONE;
		endcase

		// two-byte field collection
		if (take) begin
			if (!bif_q) begin
				partial_n = data_byte;
				bif_n     = 1'b1;
			end else begin
				bif_n = 1'b0;
			end
		end

		// extension block used up ends the walk
		if (in_ext && !left) begin
			phase_n = PH_DONE;
			bif_n   = 1'b0;
		end

		vres.kind   = ekind;
		vres.value  = eval;
		vres.grease = is_grease(eval);
		vres.err    = 1'b0;
		vres.found  = 1'b0;
		vres.last   = !final_byte;

		sres.kind   = KIND_STATUS;
		sres.value  = '0;
		sres.grease = 1'b0;
		sres.err    = ((phase_q >= PH_HSLEN) && (phase_q <= PH_EXTSLEN))
			|| ((phase_q == PH_SEARCH) && matched);
		sres.found  = (phase_q != PH_SEARCH) || matched;
		sres.last   = 1'b1;

		// pack results in order, status after any value
		po.r1 = sres;
		if (emit) begin
			po.r0 = vres;
			po.n  = final_byte ? 2'd2 : 2'd1;
		end else begin
			po.r0 = sres;
			po.n  = final_byte ? 2'd1 : 2'd0;
		end

		// end of buffer clears everything
		if (final_byte) begin
			for (int i = 0; i < 5; i++) win_n[i] = '0;
			fill_n     = '0;
			phase_n    = PH_SEARCH;
			skip_n     = '0;
			items_n    = '0;
			ext_rem_n  = '0;
			ext_type_n = '0;
			partial_n  = '0;
			bif_n      = 1'b0;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) win_q[i] <= '0;
			fill_q     <= '0;
			phase_q    <= PH_SEARCH;
			skip_q     <= '0;
			items_q    <= '0;
			ext_rem_q  <= '0;
			ext_type_q <= '0;
			partial_q  <= '0;
			bif_q      <= 1'b0;
		end else if (fire) begin
			for (int i = 0; i < 5; i++) win_q[i] <= win_n[i];
			fill_q     <= fill_n;
			phase_q    <= phase_n;
			skip_q     <= skip_n;
			items_q    <= items_n;
			ext_rem_q  <= ext_rem_n;
			ext_type_q <= ext_type_n;
			partial_q  <= partial_n;
			bif_q      <= bif_n;
		end
	end

endmodule

FILE: hdl/tch_out_queue.sv
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
module tch_out_queue
	import tch_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  parse_out_t po,
	input  logic       pop,
	output logic       head_valid,
	output result_t    head,
	output q_stat_t    stat
);

	result_t           mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic [1:0]        n_in;
	logic              n_out;
	logic [QPTR_W-1:0] wr_nxt;

	assign n_in   = push ? po.n : 2'd0;
	assign n_out  = pop && (count_q != '0);
	assign wr_nxt = wr_q + QPTR_W'(1);

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign stat.count = count_q;
	assign stat.room2 = (count_q <= QCNT_W'(QDEPTH - 2));

	// entry writes
	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wr_q] <= po.r0;
		if (n_in == 2'd2) mem_q[wr_nxt] <= po.r1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(n_in);
			rd_q    <= rd_q + QPTR_W'(n_out);
			count_q <= count_q + QCNT_W'(n_in) - QCNT_W'(n_out);
		end
	end

endmodule

FILE: hdl/tls_client_hello_field_extractor_top.sv
// top level: client hello field extractor with byte input and field output channels
// a result is written into the result queue when its byte request is accepted and is handed out from the queue head
// throughput: one byte per cycle while the queue has room; a byte that yields two results hands them out one at a time
// the input takes a byte whenever the four-entry result queue has room for two results
// reset: asynchronous, clears the parse state to header search and empties the queue
`timescale 1ns / 1ps
module tls_client_hello_field_extractor_top
	import tch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tch_byte_if.sink    in_ch,
	tch_field_if.source out_ch
);

	parse_out_t po;
	q_stat_t    qstat;
	result_t    head;
	logic       head_valid;
	logic       in_fire;
	logic       out_fire;

	assign in_ch.ready = qstat.room2;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_ch.valid && out_ch.ready;

	// byte walk
	tch_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.data_byte  (in_ch.data_byte),
		.final_byte (in_ch.final_byte),
		.po         (po)
	);

	// result buffering
	tch_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_fire),
		.po         (po),
		.pop        (out_fire),
		.head_valid (head_valid),
		.head       (head),
		.stat       (qstat)
	);

	// output channel
	assign out_ch.valid       = head_valid;
	assign out_ch.field_kind  = head.kind;
	assign out_ch.field_value = head.value;
	assign out_ch.grease_flag = head.grease;
	assign out_ch.end_error   = head.err;
	assign out_ch.hello_found = head.found;
	assign out_ch.run_last    = head.last;

	// a last byte always leaves its status in the queue
	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_ch.final_byte |=> out_ch.valid)
		else $error("no result after last byte");

	// queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	// status always closes the run of its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.field_kind == KIND_STATUS) |-> out_ch.run_last)
		else $error("status not marked last");

endmodule

FILE: dv/tb.sv
// testbench: client hello field extractor driven with buffers and checked by a field predictor
`timescale 1ns / 1ps
module tb;
	import tch_pkg::*;

	// one byte request with an optional typed-in status expectation
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       typed;
		logic       t_err;
		logic       t_found;
	} byte_req_t;

	// knobs that shape one generated client hello buffer
	typedef struct {
		int pre_noise;
		int sid_len;
		int n_cipher;
		bit odd_cs;
		int cm_len;
		int n_ext;
		int ext_adjust;
		int pad_at;
		int cut_mode;
		int post_noise;
		bit zero_lists;
	} hello_shape_t;

	localparam int CUT_NONE      = 0;
	localparam int CUT_EXTLEN    = 1;
	localparam int CUT_AFTER_LEN = 2;
	localparam int CUT_ANYWHERE  = 3;
	localparam int CUT_IN_WALK   = 4;

	localparam int BYTES_GOAL      = 1750;
	localparam int DRAIN_CYCLES    = 10;
	localparam int HOLD_OFF_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tch_byte_if  in_if ();
	tch_field_if out_if ();

	tls_client_hello_field_extractor_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	// stimulus and expectation stores
	byte_req_t byte_reqs[$];
	byte_req_t cur_req;
	result_t   pending_fields[$];
	result_t   step_fields[$];
	byte_req_t dir_tab [21];

	int bytes_total;
	int bytes_taken;
	int buffers_done;
	int fields_checked;
	int hellos_seen;
	int mism_count;
	int burst_left;
	int gap_left;
	logic hold_off;
	int rx_cycle;
	int rx_mode;

	// predictor state
	phase_t      hello_phase;
	logic [7:0]  win [5];
	logic [2:0]  win_fill;
	logic [15:0] skip_left;
	logic [15:0] list_left;
	logic [15:0] ext_left;
	logic [15:0] ext_kind;
	logic [7:0]  hi_byte;
	logic        hi_held;

	always #5 clk = ~clk;

	// predictor: clear the walk for the next buffer
	task automatic walk_clear();
		foreach (win[i]) win[i] = 8'h00;
		win_fill = 3'd0;
		hello_phase = PH_SEARCH;
		skip_left = '0;
		list_left = '0;
		ext_left = '0;
		ext_kind = '0;
		hi_byte = '0;
		hi_held = 1'b0;
	endtask

	task automatic add_field(input kind_t k, input logic [15:0] v, input logic e, input logic f);
		result_t r;
		r.kind = k;
		r.value = v;
		r.grease = (k != KIND_STATUS) && ((v & GREASE_MASK) == GREASE_PAT) && (v[15:8] == v[7:0]);
		r.err = e;
		r.found = f;
		r.last = 1'b0;
		step_fields.insert(step_fields.size(), r);
	endtask

	// big-endian 16-bit field, complete on its second byte
	task automatic take_word(input logic [7:0] d, output logic got, output logic [15:0] w);
		if (!hi_held) begin
			hi_byte = d;
			hi_held = 1'b1;
			got = 1'b0;
			w = '0;
		end else begin
			w = {hi_byte, d};
			hi_held = 1'b0;
			got = 1'b1;
		end
	endtask

	// predictor: fields caused by one byte, collected in step_fields
	task automatic walk_hello_byte(input logic [7:0] d, input logic fin);
		phase_t pre;
		logic matched;
		logic block_left;
		logic got;
		logic err;
		logic found;
		logic [15:0] w;
		pre = hello_phase;
		matched = 1'b0;
		block_left = 1'b1;
		got = 1'b0;
		w = '0;
		case (hello_phase)
			PH_SEARCH: begin
				matched = (win_fill >= WIN_DEPTH) && (win[0] == REC_HANDSHAKE) &&
					(d == HS_CLIENTHELLO);
				for (int i = 0; i < 4; i++) win[i] = win[i + 1];
				win[4] = d;
				if (win_fill < WIN_DEPTH) win_fill++;
				if (matched) begin
					hello_phase = PH_HSLEN;
					skip_left = HSLEN_BYTES;
				end
			end
			PH_HSLEN, PH_RANDOM, PH_SID, PH_CM: begin
				if (skip_left != 0) skip_left--;
				if (skip_left == 0) begin
					case (pre)
						PH_HSLEN: hello_phase = PH_VER;
						PH_RANDOM: hello_phase = PH_SIDLEN;
						PH_SID: hello_phase = PH_CSLEN;
						default: hello_phase = PH_EXTSLEN;
					endcase
				end
			end
			PH_VER: begin
				take_word(d, got, w);
				if (got) begin
					add_field(KIND_VERSION, w, 1'b0, 1'b0);
					hello_phase = PH_RANDOM;
					skip_left = RANDOM_BYTES;
				end
			end
			PH_SIDLEN: begin
				skip_left = {8'h00, d};
				if (d != 0) hello_phase = PH_SID;
				else hello_phase = PH_CSLEN;
			end
			PH_CMLEN: begin
				skip_left = {8'h00, d};
				if (d != 0) hello_phase = PH_CM;
				else hello_phase = PH_EXTSLEN;
			end
			PH_CSLEN: begin
				take_word(d, got, w);
				if (got) begin
					list_left = w >> 1;
					if (list_left != 0) hello_phase = PH_CIPHER;
					else hello_phase = PH_CMLEN;
				end
			end
			PH_CIPHER: begin
				take_word(d, got, w);
				if (got) begin
					add_field(KIND_CIPHER, w, 1'b0, 1'b0);
					if (list_left != 0) list_left--;
					if (list_left == 0) hello_phase = PH_CMLEN;
				end
			end
			PH_EXTSLEN: begin
				take_word(d, got, w);
				if (got) begin
					ext_left = w;
					if (w != 0) hello_phase = PH_ETYPE;
					else hello_phase = PH_DONE;
				end
			end
			PH_ETYPE, PH_ELEN, PH_ESKIP, PH_PFLEN, PH_PF, PH_CVLEN, PH_CV: begin
				// every walk byte uses up the extension block
				if (ext_left != 0) ext_left--;
				block_left = (ext_left != 0);
				case (pre)
					PH_ETYPE: begin
						take_word(d, got, w);
						if (got) begin
							ext_kind = w;
							hello_phase = PH_ELEN;
						end
					end
					PH_ELEN: begin
						take_word(d, got, w);
						if (got && block_left) begin
							add_field(KIND_EXT, ext_kind, 1'b0, 1'b0);
							if (ext_kind == EXT_POINTS) hello_phase = PH_PFLEN;
							else if (ext_kind == EXT_CURVES) hello_phase = PH_CVLEN;
							else if (ext_kind == EXT_PADDING) hello_phase = PH_DONE;
							else begin
								skip_left = w;
								if (w != 0) hello_phase = PH_ESKIP;
								else hello_phase = PH_ETYPE;
							end
						end
					end
					PH_ESKIP: begin
						if (skip_left != 0) skip_left--;
						if (skip_left == 0) hello_phase = PH_ETYPE;
					end
					PH_PFLEN: begin
						list_left = {8'h00, d};
						if (d != 0) hello_phase = PH_PF;
						else hello_phase = PH_ETYPE;
					end
					PH_PF: begin
						if (block_left) add_field(KIND_POINT, {8'h00, d}, 1'b0, 1'b0);
						if (list_left != 0) list_left--;
						if (list_left == 0) hello_phase = PH_ETYPE;
					end
					PH_CVLEN: begin
						take_word(d, got, w);
						if (got) begin
							list_left = w >> 1;
							if (list_left != 0) hello_phase = PH_CV;
							else hello_phase = PH_ETYPE;
						end
					end
					default: begin
						take_word(d, got, w);
						if (got) begin
							if (block_left) add_field(KIND_CURVE, w, 1'b0, 1'b0);
							if (list_left != 0) list_left--;
							if (list_left == 0) hello_phase = PH_ETYPE;
						end
					end
				endcase
				if (!block_left) begin
					hello_phase = PH_DONE;
					hi_held = 1'b0;
				end
			end
			default: hello_phase = PH_DONE;
		endcase
		// status on the last byte of the buffer
		if (fin) begin
			found = (pre != PH_SEARCH) || matched;
			err = ((pre >= PH_HSLEN) && (pre <= PH_EXTSLEN)) || ((pre == PH_SEARCH) && matched);
			add_field(KIND_STATUS, 16'h0000, err, found);
			walk_clear();
		end
		if (step_fields.size() != 0) step_fields[step_fields.size() - 1].last = 1'b1;
	endtask

	// accepted byte: predict and queue its fields
	task automatic accept_byte(input byte_req_t q);
		result_t r;
		bytes_taken++;
		if (q.fin) buffers_done++;
		step_fields.delete();
		walk_hello_byte(q.data, q.fin);
		if (q.typed) begin
			if (q.fin) begin
				r.kind = KIND_STATUS;
				r.value = '0;
				r.grease = 1'b0;
				r.err = q.t_err;
				r.found = q.t_found;
				r.last = 1'b1;
				pending_fields.insert(pending_fields.size(), r);
			end
		end else begin
			foreach (step_fields[i]) pending_fields.insert(pending_fields.size(), step_fields[i]);
		end
	endtask

	task automatic push_byte(input logic [7:0] d, input logic fin);
		byte_req_t r;
		r.data = d;
		r.fin = fin;
		r.typed = 1'b0;
		r.t_err = 1'b0;
		r.t_found = 1'b0;
		byte_reqs.insert(byte_reqs.size(), r);
	endtask

	// 16-bit value with a good share of grease and near-grease codes
	function automatic logic [15:0] pick_word();
		logic [3:0] g;
		logic [3:0] h;
		g = 4'($urandom);
		h = 4'($urandom);
		case ($urandom_range(0, 3))
			0: pick_word = {g, 4'ha, g, 4'ha};
			1: pick_word = {g, 4'ha, h, 4'ha};
			default: pick_word = 16'($urandom);
		endcase
	endfunction

	function automatic hello_shape_t plain_shape();
		hello_shape_t s;
		s.pre_noise = 0;
		s.sid_len = 4;
		s.n_cipher = 3;
		s.odd_cs = 1'b0;
		s.cm_len = 1;
		s.n_ext = 5;
		s.ext_adjust = 0;
		s.pad_at = -1;
		s.cut_mode = CUT_NONE;
		s.post_noise = 0;
		s.zero_lists = 1'b0;
		return s;
	endfunction

	function automatic hello_shape_t random_shape();
		hello_shape_t s;
		s = plain_shape();
		s.pre_noise = $urandom_range(0, 3);
		case ($urandom_range(0, 3))
			0: s.sid_len = 0;
			1: s.sid_len = 32;
			default: s.sid_len = $urandom_range(0, 8);
		endcase
		s.n_cipher = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
		s.odd_cs = ($urandom_range(0, 7) == 0);
		s.cm_len = $urandom_range(0, 3);
		s.n_ext = $urandom_range(0, 6);
		case ($urandom_range(0, 19))
			0, 1: s.ext_adjust = -int'($urandom_range(1, 6));
			2, 3: s.ext_adjust = $urandom_range(1, 8);
			4: s.ext_adjust = $urandom_range(20000, 65535);
			default: s.ext_adjust = 0;
		endcase
		s.pad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, s.n_ext) : -1;
		s.cut_mode = ($urandom_range(0, 6) == 0) ? CUT_IN_WALK : CUT_NONE;
		s.post_noise = $urandom_range(0, 4);
		s.zero_lists = ($urandom_range(0, 7) == 0);
		return s;
	endfunction

	// one buffer: noise, record header, client hello, noise, cut where asked
	task automatic add_hello(input hello_shape_t s);
		logic [7:0] hs[$];
		logic [7:0] ext[$];
		logic [15:0] v;
		int m;
		int ext_len;
		int extlen_pos;
		int cut;
		for (int i = 0; i < s.pre_noise; i++) hs.insert(hs.size(), 8'($urandom));
		hs.insert(hs.size(), REC_HANDSHAKE);
		hs.insert(hs.size(), 8'h03);
		hs.insert(hs.size(), 8'($urandom_range(0, 4)));
		hs.insert(hs.size(), 8'($urandom));
		hs.insert(hs.size(), 8'($urandom));
		hs.insert(hs.size(), HS_CLIENTHELLO);
		for (int i = 0; i < 3; i++) hs.insert(hs.size(), 8'($urandom));
		v = ($urandom_range(0, 1) == 0) ? 16'h0303 : pick_word();
		hs.insert(hs.size(), v[15:8]);
		hs.insert(hs.size(), v[7:0]);
		for (int i = 0; i < 32; i++) hs.insert(hs.size(), 8'($urandom));
		hs.insert(hs.size(), 8'(s.sid_len));
		for (int i = 0; i < s.sid_len; i++) hs.insert(hs.size(), 8'($urandom));
		v = 16'(2 * s.n_cipher + int'(s.odd_cs));
		hs.insert(hs.size(), v[15:8]);
		hs.insert(hs.size(), v[7:0]);
		for (int i = 0; i < s.n_cipher; i++) begin
			v = pick_word();
			hs.insert(hs.size(), v[15:8]);
			hs.insert(hs.size(), v[7:0]);
		end
		hs.insert(hs.size(), 8'(s.cm_len));
		for (int i = 0; i < s.cm_len; i++) hs.insert(hs.size(), 8'($urandom));
		// extension list
		for (int e = 0; e < s.n_ext; e++) begin
			if (e == s.pad_at) begin
				m = $urandom_range(0, 3);
				ext.insert(ext.size(), EXT_PADDING[15:8]);
				ext.insert(ext.size(), EXT_PADDING[7:0]);
				ext.insert(ext.size(), 8'h00);
				ext.insert(ext.size(), 8'(m));
				for (int i = 0; i < m; i++) ext.insert(ext.size(), 8'h00);
			end else begin
				case ($urandom_range(0, 7))
					0, 1: begin
						m = s.zero_lists ? 0 : $urandom_range(0, 4);
						ext.insert(ext.size(), EXT_CURVES[15:8]);
						ext.insert(ext.size(), EXT_CURVES[7:0]);
						ext.insert(ext.size(), 8'h00);
						ext.insert(ext.size(), 8'(2 + 2 * m));
						ext.insert(ext.size(), 8'h00);
						ext.insert(ext.size(), 8'(2 * m));
						for (int i = 0; i < m; i++) begin
							v = pick_word();
							ext.insert(ext.size(), v[15:8]);
							ext.insert(ext.size(), v[7:0]);
						end
					end
					2, 3: begin
						m = s.zero_lists ? 0 : $urandom_range(0, 3);
						ext.insert(ext.size(), EXT_POINTS[15:8]);
						ext.insert(ext.size(), EXT_POINTS[7:0]);
						ext.insert(ext.size(), 8'h00);
						ext.insert(ext.size(), 8'(1 + m));
						ext.insert(ext.size(), 8'(m));
						for (int i = 0; i < m; i++) ext.insert(ext.size(), 8'($urandom));
					end
					default: begin
						m = s.zero_lists ? 0 : $urandom_range(0, 5);
						v = pick_word();
						ext.insert(ext.size(), v[15:8]);
						ext.insert(ext.size(), v[7:0]);
						ext.insert(ext.size(), 8'h00);
						ext.insert(ext.size(), 8'(m));
						for (int i = 0; i < m; i++) ext.insert(ext.size(), 8'($urandom));
					end
				endcase
			end
		end
		ext_len = ext.size() + s.ext_adjust;
		if (ext_len < 0) ext_len = 0;
		if (ext_len > 65535) ext_len = 65535;
		v = 16'(ext_len);
		hs.insert(hs.size(), v[15:8]);
		extlen_pos = hs.size();
		hs.insert(hs.size(), v[7:0]);
		foreach (ext[i]) hs.insert(hs.size(), ext[i]);
		for (int i = 0; i < s.post_noise; i++) hs.insert(hs.size(), 8'($urandom));
		// where the buffer ends
		case (s.cut_mode)
			CUT_EXTLEN: cut = extlen_pos;
			CUT_AFTER_LEN: cut = extlen_pos + 1;
			CUT_ANYWHERE: cut = $urandom_range(0, hs.size() - 1);
			CUT_IN_WALK: cut = $urandom_range(extlen_pos + 1, hs.size() - 1);
			default: cut = hs.size() - 1;
		endcase
		if (cut > hs.size() - 1) cut = hs.size() - 1;
		for (int i = 0; i <= cut; i++) push_byte(hs[i], i == cut);
	endtask

	task automatic add_noise_buffer();
		int n;
		n = $urandom_range(1, 30);
		for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
	endtask

	task automatic report_field(input string why, input result_t e);
		mism_count++;
		if (mism_count <= 10)
			$display("mismatch (%s): exp kind %0d val %h gr %b err %b fnd %b last %b", why,
				e.kind, e.value, e.grease, e.err, e.found, e.last,
				" / got kind %0d val %h gr %b err %b fnd %b last %b",
				out_if.field_kind, out_if.field_value, out_if.grease_flag,
				out_if.end_error, out_if.hello_found, out_if.run_last);
	endtask

	// byte sender: bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.data_byte <= 8'h00;
			in_if.final_byte <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_if.valid && in_if.ready) accept_byte(cur_req);
			if (!(in_if.valid && !in_if.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_if.valid <= 1'b0;
				end else if (byte_reqs.size() != 0) begin
					cur_req = byte_reqs.pop_front();
					in_if.data_byte <= cur_req.data;
					in_if.final_byte <= cur_req.fin;
					in_if.valid <= 1'b1;
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// field receiver: stall pattern picked at random from four modes, redrawn as rx_cycle counts on
	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			rx_cycle <= 0;
			rx_mode <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 256 == 255) rx_mode <= $urandom_range(0, 3);
			if (hold_off) out_if.ready <= 1'b0;
			else begin
				case (rx_mode)
					0: out_if.ready <= 1'b1;
					1: out_if.ready <= ($urandom_range(0, 1) == 0);
					2: out_if.ready <= (rx_cycle % 3 == 0);
					default: out_if.ready <= ($urandom_range(0, 6) != 0);
				endcase
			end
		end
	end

	// field checker
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			fields_checked++;
			if (pending_fields.size() == 0) begin
				report_field("nothing expected", '0);
			end else begin
				if (out_if.field_kind === KIND_STATUS && out_if.hello_found === 1'b1)
					hellos_seen++;
				if ((out_if.field_kind !== pending_fields[0].kind) ||
					(out_if.field_value !== pending_fields[0].value) ||
					(out_if.grease_flag !== pending_fields[0].grease) ||
					(out_if.end_error !== pending_fields[0].err) ||
					(out_if.hello_found !== pending_fields[0].found) ||
					(out_if.run_last !== pending_fields[0].last))
					report_field("field", pending_fields[0]);
				void'(pending_fields.pop_front());
			end
		end
	end

	// long receiver hold-off so the result queue fills and the input stalls
	initial begin
		hold_off = 1'b0;
		while (bytes_taken < 300) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		hello_shape_t s;
		in_if.valid = 1'b0;
		in_if.data_byte = 8'h00;
		in_if.final_byte = 1'b0;
		out_if.ready = 1'b0;
		bytes_taken = 0;
		buffers_done = 0;
		fields_checked = 0;
		hellos_seen = 0;
		mism_count = 0;
		walk_clear();

		// data, final, typed, err, found
		dir_tab = '{
			// single byte buffers, no header
			'{8'hff, 1'b1, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
			// header matched on the last byte
			'{8'h16, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h01, 1'b1, 1'b1, 1'b1, 1'b1},
			// buffer ends inside the handshake length
			'{8'h16, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h03, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h01, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'ha5, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h01, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
			// type byte only four bytes after the record byte
			'{8'h16, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
			'{8'h01, 1'b1, 1'b1, 1'b0, 1'b0}
		};
		foreach (dir_tab[i]) byte_reqs.insert(byte_reqs.size(), dir_tab[i]);

		// directed hellos, checked by the predictor
		s = plain_shape();
		add_hello(s);
		s.n_ext = 0;
		s.post_noise = 3;
		add_hello(s);
		s = plain_shape();
		s.ext_adjust = -2;
		add_hello(s);
		s = plain_shape();
		s.zero_lists = 1'b1;
		s.n_cipher = 0;
		s.sid_len = 0;
		s.cm_len = 0;
		add_hello(s);
		s = plain_shape();
		s.pad_at = 1;
		s.post_noise = 2;
		add_hello(s);
		s = plain_shape();
		s.cut_mode = CUT_EXTLEN;
		add_hello(s);
		s.cut_mode = CUT_AFTER_LEN;
		add_hello(s);
		s = plain_shape();
		s.ext_adjust = 30000;
		s.cut_mode = CUT_IN_WALK;
		add_hello(s);
		s = plain_shape();
		s.odd_cs = 1'b1;
		s.sid_len = 255;
		add_hello(s);

		// random buffers: mostly well-formed hellos, some broken, some noise
		while (byte_reqs.size() < BYTES_GOAL) begin
			case ($urandom_range(0, 9))
				0: add_noise_buffer();
				1: begin
					s = random_shape();
					s.cut_mode = CUT_ANYWHERE;
					add_hello(s);
				end
				default: add_hello(random_shape());
			endcase
		end
		bytes_total = byte_reqs.size();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_taken < bytes_total) @(posedge clk);
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d bytes in %0d buffers, %0d client hellos matched",
			bytes_taken, buffers_done, hellos_seen);
		$display("summary: %0d fields checked, %0d mismatches", fields_checked, mism_count);
		if (mism_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
